>>> sv/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants for the remote packet deframer.
// ----------------------------------------------------------------------------
package rpd_pkg;

  localparam int WinLen     = 6;
  localparam int FillWidth  = 3;

  typedef logic [7:0]           byte_t;
  typedef logic [15:0]          word_t;
  typedef logic [FillWidth-1:0] fill_t;
  typedef byte_t                window_t [WinLen];

  localparam byte_t SyncFirst  = 8'hFF;
  localparam byte_t SyncSecond = 8'h55;
  localparam word_t NoData     = 16'hFFFF;

endpackage

>>> sv/remote_packet_deframer.sv
// ----------------------------------------------------------------------------
// remote_packet_deframer
// Byte-stream deframer for FF 55 lo ~lo hi ~hi remote packets.
// ----------------------------------------------------------------------------
// Takes one byte per clock while in_ready is high. Each accepted byte goes
// into a six-byte receive window, and the window update, sync search, realign
// shift and complement check all finish in the cycle the byte is accepted, so
// a completed packet's word is registered into command_word, or into the skid
// entry while the output stalls. A two-entry output stage (result register
// plus skid) holds one extra word, so input keeps flowing while the output
// side stalls until a second word is waiting; in_ready drops only while both
// output entries are full. Sustained rate is one byte per cycle. Words equal
// to FFFF and packets failing the complement checks are dropped silently.
module remote_packet_deframer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rpd_pkg::byte_t    rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output rpd_pkg::word_t    command_word
);
  import rpd_pkg::*;

  window_t window;
  window_t window_next;
  fill_t   fill;
  fill_t   fill_next;
  logic    emit;
  word_t   word_next;

  logic    skid_valid;
  word_t   skid_word;

  // window update and decode for the byte on rx_byte
  window_t staged;
  fill_t   staged_fill;
  logic    found;
  fill_t   pos;
  word_t   decoded;

  always_comb begin
    staged      = window;
    staged_fill = fill;
    if (fill < fill_t'(WinLen)) begin
      staged[fill[FillWidth-1:0]] = rx_byte;
      staged_fill = fill + fill_t'(1);
    end

    found = 1'b0;
    pos   = '0;
    for (int p = WinLen - 2; p >= 0; p--) begin
      if (staged[p] == SyncFirst && staged[p+1] == SyncSecond) begin
        found = 1'b1;
        pos   = fill_t'(p);
      end
    end

    decoded     = {staged[4], staged[2]};
    window_next = staged;
    fill_next   = staged_fill;
    emit        = 1'b0;
    word_next   = decoded;

    if (staged_fill >= fill_t'(WinLen)) begin
      if (!found) begin
        if (staged[WinLen-1] == SyncFirst) begin
          window_next[0] = SyncFirst;
          fill_next      = fill_t'(1);
        end else begin
          fill_next = '0;
        end
      end else if (pos != '0) begin
        // realign so the sync pair sits at the start
        for (int p = 1; p <= WinLen - 2; p++) begin
          if (pos == fill_t'(p)) begin
            for (int k = 0; k < WinLen - p; k++) begin
              window_next[k] = staged[k+p];
            end
          end
        end
        fill_next = fill_t'(WinLen) - pos;
      end else begin
        fill_next = '0;
        emit = (staged[2] == ~staged[3]) && (staged[4] == ~staged[5]) &&
               (decoded != NoData);
      end
    end
  end

  assign in_ready = !skid_valid;

  logic accept;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  // output register with one skid entry
  logic new_word;
  assign new_word = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (skid_valid) begin
          out_valid    <= 1'b1;
          command_word <= skid_word;
          skid_valid   <= new_word;
          skid_word    <= word_next;
        end else begin
          out_valid    <= new_word;
          command_word <= word_next;
        end
      end else if (new_word) begin
        skid_valid <= 1'b1;
        skid_word  <= word_next;
      end
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill < fill_t'(WinLen))
    else $error("fill count out of range");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a word while output register is empty");

  a_no_sentinel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> command_word != NoData)
    else $error("no-data sentinel presented as a word");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    new_word |=> fill == '0)
    else $error("window not cleared after a decoded packet");

endmodule

>>> test/tb_remote_packet_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_remote_packet_deframer
// Self-checking bench for the FF 55 remote packet deframer.
// ----------------------------------------------------------------------------
// Bytes are queued up front: a few hand-built packets (sentinel, bad
// complement, lost sync, realign), then mostly clean packets with random
// payload mixed with corrupted packets and line noise. A local window model
// predicts each decoded word as bytes are accepted; the monitor compares
// what comes out, in order. Both sides stall at random, and the receiver
// holds off once for a long stretch to back the block up.
module tb_remote_packet_deframer;
  import rpd_pkg::*;

  localparam int StallLimit = 3000;
  localparam int HoldLen    = 300;
  localparam int ByteTarget = 850;

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  byte_t rx_byte   = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  word_t command_word;

  remote_packet_deframer uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .command_word (command_word)
  );

  always #4 clk = ~clk;

  byte_t pending [$];
  word_t expected_words [$];

  // window model
  byte_t win [WinLen];
  int    win_fill = 0;

  int total_bytes   = 0;
  int bytes_sent    = 0;
  int words_checked = 0;
  int realigns      = 0;
  int dropped       = 0;
  int err_count     = 0;
  int idle_cycles   = 0;

  logic in_acc  = 1'b0;
  logic out_acc = 1'b0;
  int   send_gap  = 0;
  bit   send_calm = 1'b0;
  int   recv_gap  = 0;
  bit   recv_calm = 1'b0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic void deframe_byte(input byte_t b);
    int    sync_at;
    word_t w;
    sync_at = -1;
    if (win_fill < WinLen) begin
      win[win_fill] = b;
      win_fill++;
    end
    if (win_fill < WinLen) return;
    for (int k = 0; k < WinLen - 1; k++)
      if (sync_at < 0 && win[k] == SyncFirst && win[k+1] == SyncSecond) sync_at = k;
    if (sync_at < 0) begin
      // keep a trailing FF, it may start the next sync pair
      if (win[WinLen-1] == SyncFirst) begin
        win[0]   = SyncFirst;
        win_fill = 1;
      end else begin
        win_fill = 0;
      end
    end else if (sync_at > 0) begin
      for (int k = sync_at; k < WinLen; k++) win[k-sync_at] = win[k];
      win_fill = WinLen - sync_at;
      realigns++;
    end else begin
      win_fill = 0;
      w = {win[4], win[2]};
      if (win[2] == ~win[3] && win[4] == ~win[5] && w != NoData)
        expected_words.push_back(w);
      else
        dropped++;
    end
  endfunction

  function automatic void add_packet(input byte_t lo, input byte_t hi);
    pending.push_back(SyncFirst);
    pending.push_back(SyncSecond);
    pending.push_back(lo);
    pending.push_back(~lo);
    pending.push_back(hi);
    pending.push_back(~hi);
  endfunction

  function automatic void add_bytes(input byte_t b []);
    foreach (b[k]) pending.push_back(b[k]);
  endfunction

  // stimulus and end of run
  initial begin
    byte_t lo, hi;
    int    pick, at, n;

    add_packet(8'h00, 8'h00);                       // smallest word
    add_packet(8'hFF, 8'hFF);                       // no-data sentinel, dropped
    add_bytes('{8'hFF, 8'h55, 8'h12, 8'hED, 8'h56, 8'h00});  // high complement bad
    add_bytes('{8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'hFF});  // no sync, FF kept
    add_bytes('{8'h00, 8'hFF, 8'h55, 8'hFE, 8'h01});         // sync at offset 2
    add_bytes('{8'hFF, 8'h00});                     // completes word FFFE

    while (pending.size() < ByteTarget) begin
      pick = $urandom_range(0, 9);
      lo   = byte_t'($urandom_range(0, 255));
      hi   = byte_t'($urandom_range(0, 255));
      case ($urandom_range(0, 15))
        0: begin lo = 8'hFF; hi = 8'hFF; end
        1: begin lo = 8'h00; hi = 8'h00; end
        2: hi = 8'hFF;
        default: ;
      endcase
      if (pick <= 5) begin
        add_packet(lo, hi);
      end else if (pick <= 7) begin
        add_packet(lo, hi);
        at = pending.size() - 6 + $urandom_range(0, 5);
        pending[at] = pending[at] ^ byte_t'($urandom_range(1, 255));
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) pending.push_back(SyncFirst);
          else pending.push_back(byte_t'($urandom_range(0, 255)));
        end
      end
    end
    total_bytes = pending.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (bytes_sent < total_bytes || expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d words never came out", expected_words.size()));

    $display("Covered %0d bytes: %0d words checked, %0d realigns, %0d packets dropped",
             total_bytes, words_checked, realigns, dropped);
    $display("(bad complement or sentinel), with random stalls and one long output hold.");
    if (err_count == 0) begin
      $display("tb_remote_packet_deframer: done, clean");
    end else begin
      $display("tb_remote_packet_deframer: done, errors");
    end
    $finish;
  end

  // byte driver: hold until taken, then an optional gap before the next one
  always @(negedge clk) begin
    if (!rst && !(in_valid && !in_acc)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending.size() > 0) begin
        rx_byte  <= pending.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) send_calm <= !send_calm;
        send_gap <= send_calm ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // word receiver
  always @(negedge clk) begin
    int g;
    if (!rst) begin
      g = recv_gap;
      if (out_acc) begin
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        g = recv_calm ? 0 : $urandom_range(0, 4);
      end else if (g > 0) begin
        g--;
      end
      recv_gap <= g;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && words_checked >= 30) begin
        // long back-pressure so the input side has to stall
        hold_done <= 1'b1;
        hold_left <= HoldLen;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (g == 0);
      end
    end
  end

  // monitor, model update and watchdog
  always @(posedge clk) begin
    word_t want;
    in_acc  <= in_valid && in_ready;
    out_acc <= out_valid && out_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", command_word));
        end else begin
          want = expected_words.pop_front();
          if (command_word !== want)
            report_mismatch($sformatf("command_word %h, want %h", command_word, want));
          words_checked++;
        end
      end
      if (in_valid && in_ready) begin
        deframe_byte(rx_byte);
        bytes_sent++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("Timeout: %0d cycles with no word moving", idle_cycles);
          $display("tb_remote_packet_deframer: done, errors");
          $finish;
        end
      end
    end
  end

endmodule
